// ===== rtl/fra_pkg.sv =====
// Shared types and codes for the rational fraction ALU.
`timescale 1ns / 1ps
package fra_pkg;

  localparam int WIDTH_DEF = 32;

  localparam logic [1:0] FN_ADD = 2'd0;
  localparam logic [1:0] FN_SUB = 2'd1;
  localparam logic [1:0] FN_MUL = 2'd2;
  localparam logic [1:0] FN_DIV = 2'd3;

  localparam logic [1:0] ERR_OK   = 2'd0;
  localparam logic [1:0] ERR_ZERO = 2'd1;
  localparam logic [1:0] ERR_OVF  = 2'd2;

  // Work steps that run on the shared multiply/divide unit.
  typedef enum logic [8:0] {
    ST_GCD = 9'b000000001,
    ST_Q1  = 9'b000000010,
    ST_LCM = 9'b000000100,
    ST_F1  = 9'b000001000,
    ST_S1  = 9'b000010000,
    ST_F2  = 9'b000100000,
    ST_S2  = 9'b001000000,
    ST_PN  = 9'b010000000,
    ST_PD  = 9'b100000000
  } fra_step_t;

  // Request from the sequencer to the shared unit.
  typedef struct packed {
    logic start;
    logic is_div;
  } fra_req_t;

endpackage

// ===== rtl/fra_unit.sv =====
// Shared iterative unit: shift-add multiplier and restoring divider, one bit per cycle.
`timescale 1ns / 1ps
module fra_unit import fra_pkg::*; #(
  parameter int WIDTH = WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  fra_req_t         req,
  input  logic [WIDTH-1:0] op_a,
  input  logic [WIDTH-1:0] op_b,
  output logic             done,
  output logic [WIDTH-1:0] res_lo,  // product low half or quotient
  output logic [WIDTH-1:0] res_hi   // product high half or remainder
);

  localparam int CW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] hi_r, lo_r, b_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r, div_r, done_r;
  logic [WIDTH:0]   sum, trial, diff;

  assign sum   = {1'b0, hi_r} + (lo_r[0] ? {1'b0, b_r} : '0);
  assign trial = {hi_r, lo_r[WIDTH-1]};
  assign diff  = trial - {1'b0, b_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        div_r  <= req.is_div;
        cnt_r  <= CW'(WIDTH);
        hi_r   <= '0;
        if (req.is_div) begin
          lo_r <= op_a;
          b_r  <= op_b;
        end else begin
          lo_r <= op_b;
          b_r  <= op_a;
        end
      end else if (busy_r) begin
        if (div_r) begin
          if (!diff[WIDTH]) begin
            hi_r <= diff[WIDTH-1:0];
            lo_r <= {lo_r[WIDTH-2:0], 1'b1};
          end else begin
            hi_r <= trial[WIDTH-1:0];
            lo_r <= {lo_r[WIDTH-2:0], 1'b0};
          end
        end else begin
          hi_r <= sum[WIDTH:1];
          lo_r <= {sum[0], lo_r[WIDTH-1:1]};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done   = done_r;
  assign res_lo = lo_r;
  assign res_hi = hi_r;

endmodule

// ===== rtl/rational_fraction_alu.sv =====
// Top level of the rational fraction ALU: request capture, sequencer and result register.
`timescale 1ns / 1ps
// The block takes one request holding two fractions (signed numerator over unsigned
// denominator) and an operation code in in_tuser (add, subtract, multiply, divide), and
// returns one unreduced result fraction with an error code in out_tuser. All work runs on
// one shared unit that multiplies or divides WIDTH bits one bit per cycle. Multiply and divide
// take two unit operations, and add and subtract with equal denominators use none of them.
// With unequal denominators they need the gcd (one division per Euclid step, at most
// about 1.44 * WIDTH steps, usually far fewer) plus six more unit operations. The input
// is not ready while a request is being worked on; a finished result waits in the output
// register while the next request is accepted. Zero denominators and a zero divisor give
// error 1, results that do not fit give error 2, and in both cases the fraction is zero.
module rational_fraction_alu import fra_pkg::*; #(
  parameter int WIDTH = WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // Fields from bit 0 up: a_num, a_den, b_num, b_den, zero padding.
  input  logic [((4*WIDTH+7)/8)*8-1:0]      in_tdata,
  // Fields from bit 0 up: func.
  input  logic [1:0]                        in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // Fields from bit 0 up: res_num, res_den, zero padding.
  output logic [((2*WIDTH+7)/8)*8-1:0]      out_tdata,
  // Fields from bit 0 up: error.
  output logic [1:0]                        out_tuser
);

  localparam int DW_OUT = ((2*WIDTH+7)/8)*8;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DEC   = 6'b000010,
    S_ISSUE = 6'b000100,
    S_WAIT  = 6'b001000,
    S_ADD   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t           state_r, state_nxt;
  fra_step_t        step_r;
  logic [1:0]       func_r, err_r;
  logic             an_neg_r, bn_neg_r, s1_neg_r, s2_neg_r, rn_neg_r;
  logic [WIDTH-1:0] an_mag_r, bn_mag_r, ad_r, bd_r;
  logic [WIDTH-1:0] x_r, y_r, f_r, l_r, s1_r, s2_r, rn_r, rd_r;
  logic             out_valid_r;
  logic [WIDTH-1:0] res_num_r, res_den_r;
  logic [1:0]       res_err_r;

  logic [WIDTH-1:0] a_num_in, b_num_in;
  fra_req_t         req;
  logic [WIDTH-1:0] op_a, op_b, u_lo, u_hi;
  logic             u_done;
  logic             mul_neg, mul_fits;
  logic             add_neg, add_ok;
  logic [WIDTH:0]   add_mag, add_lim;
  logic             fire;

  assign a_num_in = in_tdata[WIDTH-1:0];
  assign b_num_in = in_tdata[3*WIDTH-1:2*WIDTH];
  assign fire     = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);

  // Operand selection for the shared unit.
  always_comb begin
    op_a = ad_r;
    op_b = bd_r;
    req  = '{start: 1'b0, is_div: 1'b0};
    if (state_r == S_ISSUE) begin
      case (step_r)
        ST_GCD: begin
          op_a = y_r; op_b = x_r;
          req  = '{start: (x_r != '0), is_div: 1'b1};
        end
        ST_Q1:  begin op_a = ad_r;     op_b = y_r;  req = '{start: 1'b1, is_div: 1'b1}; end
        ST_LCM: begin op_a = f_r;      op_b = bd_r; req = '{start: 1'b1, is_div: 1'b0}; end
        ST_F1:  begin op_a = l_r;      op_b = ad_r; req = '{start: 1'b1, is_div: 1'b1}; end
        ST_S1:  begin op_a = an_mag_r; op_b = f_r;  req = '{start: 1'b1, is_div: 1'b0}; end
        ST_F2:  begin op_a = l_r;      op_b = bd_r; req = '{start: 1'b1, is_div: 1'b1}; end
        ST_S2:  begin op_a = bn_mag_r; op_b = f_r;  req = '{start: 1'b1, is_div: 1'b0}; end
        ST_PN: begin
          op_a = an_mag_r;
          op_b = (func_r == FN_MUL) ? bn_mag_r : bd_r;
          req  = '{start: 1'b1, is_div: 1'b0};
        end
        ST_PD: begin
          op_a = ad_r;
          op_b = (func_r == FN_MUL) ? bd_r : bn_mag_r;
          req  = '{start: 1'b1, is_div: 1'b0};
        end
        default: req = '{start: 1'b0, is_div: 1'b0};
      endcase
    end
  end

  fra_unit #(.WIDTH(WIDTH)) u_unit (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req),
    .op_a   (op_a),
    .op_b   (op_b),
    .done   (u_done),
    .res_lo (u_lo),
    .res_hi (u_hi)
  );

  // Sign of the product at hand, and whether its magnitude fits the signed range.
  always_comb begin
    case (step_r)
      ST_S1:   mul_neg = an_neg_r;
      ST_S2:   mul_neg = bn_neg_r;
      default: mul_neg = an_neg_r ^ bn_neg_r;
    endcase
    mul_fits = (u_hi == '0) &&
               (!u_lo[WIDTH-1] || (mul_neg && (u_lo[WIDTH-2:0] == '0)));
  end

  // Signed-magnitude add of the two scaled numerators.
  always_comb begin
    if (s1_neg_r == s2_neg_r) begin
      add_mag = {1'b0, s1_r} + {1'b0, s2_r};
      add_neg = s1_neg_r;
    end else if (s1_r >= s2_r) begin
      add_mag = {1'b0, s1_r} - {1'b0, s2_r};
      add_neg = s1_neg_r;
    end else begin
      add_mag = {1'b0, s2_r} - {1'b0, s1_r};
      add_neg = s2_neg_r;
    end
    if (add_mag == '0) add_neg = 1'b0;
    add_lim = ((WIDTH+1)'(1) << (WIDTH-1)) - {{WIDTH{1'b0}}, !add_neg};
    add_ok  = (add_mag <= add_lim);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (fire) state_nxt = S_DEC;
      S_DEC: begin
        if (ad_r == '0 || bd_r == '0 || (func_r == FN_DIV && bn_mag_r == '0)) begin
          state_nxt = S_OUT;
        end else if ((func_r == FN_ADD || func_r == FN_SUB) && ad_r == bd_r) begin
          state_nxt = S_ADD;
        end else begin
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: if (req.start) state_nxt = S_WAIT;
      S_WAIT: begin
        if (u_done) begin
          case (step_r)
            ST_LCM:  state_nxt = (u_hi != '0) ? S_OUT : S_ISSUE;
            ST_S1,
            ST_PN:   state_nxt = mul_fits ? S_ISSUE : S_OUT;
            ST_S2:   state_nxt = mul_fits ? S_ADD : S_OUT;
            ST_PD:   state_nxt = S_OUT;
            default: state_nxt = S_ISSUE;
          endcase
        end
      end
      S_ADD:   state_nxt = S_OUT;
      S_OUT:   if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      step_r      <= ST_GCD;
      err_r       <= ERR_OK;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (fire) begin
            func_r   <= in_tuser;
            an_neg_r <= a_num_in[WIDTH-1];
            an_mag_r <= a_num_in[WIDTH-1] ? (~a_num_in + 1'b1) : a_num_in;
            bn_neg_r <= b_num_in[WIDTH-1];
            bn_mag_r <= b_num_in[WIDTH-1] ? (~b_num_in + 1'b1) : b_num_in;
            ad_r     <= in_tdata[2*WIDTH-1:WIDTH];
            bd_r     <= in_tdata[4*WIDTH-1:3*WIDTH];
            err_r    <= ERR_OK;
          end
        end
        S_DEC: begin
          x_r <= ad_r;
          y_r <= bd_r;
          if (ad_r == '0 || bd_r == '0 || (func_r == FN_DIV && bn_mag_r == '0)) begin
            err_r <= ERR_ZERO;
          end else if (func_r == FN_ADD || func_r == FN_SUB) begin
            // Subtract flips the right sign; a zero magnitude stays positive.
            if (func_r == FN_SUB && bn_mag_r != '0) bn_neg_r <= !bn_neg_r;
            step_r   <= ST_GCD;
            s1_neg_r <= an_neg_r;
            s1_r     <= an_mag_r;
            s2_neg_r <= (func_r == FN_SUB && bn_mag_r != '0) ? !bn_neg_r : bn_neg_r;
            s2_r     <= bn_mag_r;
            rd_r     <= ad_r;
          end else begin
            step_r <= ST_PN;
          end
        end
        S_ISSUE: begin
          // Euclid ends when the divisor reaches zero; the gcd is then in y.
          if (step_r == ST_GCD && x_r == '0) step_r <= ST_Q1;
        end
        S_WAIT: begin
          if (u_done) begin
            case (step_r)
              ST_GCD: begin x_r <= u_hi; y_r <= x_r; end
              ST_Q1:  begin f_r <= u_lo; step_r <= ST_LCM; end
              ST_LCM: begin
                l_r    <= u_lo;
                step_r <= ST_F1;
                if (u_hi != '0) err_r <= ERR_OVF;
              end
              ST_F1:  begin f_r <= u_lo; step_r <= ST_S1; end
              ST_S1: begin
                s1_neg_r <= mul_neg && (u_lo != '0);
                s1_r     <= u_lo;
                step_r   <= ST_F2;
                if (!mul_fits) err_r <= ERR_OVF;
              end
              ST_F2:  begin f_r <= u_lo; step_r <= ST_S2; end
              ST_S2: begin
                s2_neg_r <= mul_neg && (u_lo != '0);
                s2_r     <= u_lo;
                rd_r     <= l_r;
                if (!mul_fits) err_r <= ERR_OVF;
              end
              ST_PN: begin
                rn_neg_r <= mul_neg && (u_lo != '0);
                rn_r     <= u_lo;
                step_r   <= ST_PD;
                if (!mul_fits) err_r <= ERR_OVF;
              end
              ST_PD: begin
                rd_r <= u_lo;
                if (u_hi != '0) err_r <= ERR_OVF;
              end
              default: err_r <= err_r;
            endcase
          end
        end
        S_ADD: begin
          rn_neg_r <= add_neg;
          rn_r     <= add_mag[WIDTH-1:0];
          if (!add_ok) err_r <= ERR_OVF;
        end
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            res_err_r   <= err_r;
            if (err_r != ERR_OK) begin
              res_num_r <= '0;
              res_den_r <= '0;
            end else begin
              res_num_r <= rn_neg_r ? (~rn_r + 1'b1) : rn_r;
              res_den_r <= rd_r;
            end
          end
        end
        default: err_r <= err_r;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = DW_OUT'({res_den_r, res_num_r});
  assign out_tuser  = res_err_r;

endmodule

// ===== rtl/fra_checker.sv =====
// Port-level checks for the rational fraction ALU, bound to the top level.
`timescale 1ns / 1ps
module fra_checker import fra_pkg::*; #(
  parameter int WIDTH = WIDTH_DEF
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_tvalid,
  input logic                         in_tready,
  input logic [((4*WIDTH+7)/8)*8-1:0] in_tdata,
  input logic [1:0]                   in_tuser,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [((2*WIDTH+7)/8)*8-1:0] out_tdata,
  input logic [1:0]                   out_tuser
);

  // A result that waits keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // A flagged result carries a zero fraction.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ERR_OK |-> out_tdata == '0)
    else $error("flagged result has nonzero fraction");

  // The error code is one of the defined ones.
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser != 2'd3)
    else $error("undefined error code");

  // A request occupies the block: no second request on the next edge.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted back to back");

endmodule

bind rational_fraction_alu fra_checker #(.WIDTH(WIDTH)) u_fra_checker (.*);

// ===== tb/rational_fraction_alu_tb.sv =====
// Testbench for the rational fraction ALU: directed and random requests checked against a local model.
`timescale 1ns / 1ps
module rational_fraction_alu_tb;
  import fra_pkg::*;

  localparam int W = 32;
  localparam int CYCLE_LIMIT = 20000000;

  typedef struct packed {
    logic [W-1:0] num;
    logic [W-1:0] den;
    logic [1:0]   err;
  } frac_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [4*W-1:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [2*W-1:0] out_tdata;
  logic [1:0] out_tuser;

  frac_res_t pending_results[$];
  int errors = 0;
  int cycles = 0;
  bit rx_busy = 1'b0;

  rational_fraction_alu #(.WIDTH(W)) DUT (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Signed magnitude helpers for the arithmetic model, all on 64-bit values.
  localparam longint unsigned WMASK = 64'hFFFF_FFFF;
  localparam longint unsigned SMAX = 64'h7FFF_FFFF;

  function automatic longint unsigned lim_for(bit neg);
    return neg ? SMAX + 1 : SMAX;
  endfunction

  function automatic bit umul_fits(longint unsigned x, longint unsigned y,
                                   longint unsigned lim, output longint unsigned r);
    r = x * y;
    if (x != 0 && y > lim / x) return 1'b0;
    return r <= lim;
  endfunction

  function automatic bit smul_fits(bit xn, longint unsigned xm, bit yn, longint unsigned ym,
                                   output bit rn, output longint unsigned rm);
    bit n;
    n = xn ^ yn;
    if (!umul_fits(xm, ym, lim_for(n), rm)) return 1'b0;
    rn = n && rm != 0;
    return 1'b1;
  endfunction

  function automatic bit sadd_fits(bit xn, longint unsigned xm, bit yn, longint unsigned ym,
                                   output bit rn, output longint unsigned rm);
    if (xn == yn) begin
      if (xm > lim_for(xn) || ym > lim_for(xn) - xm) return 1'b0;
      rn = xn;
      rm = xm + ym;
    end else if (xm >= ym) begin
      rn = xn;
      rm = xm - ym;
    end else begin
      rn = yn;
      rm = ym - xm;
    end
    if (rm == 0) rn = 1'b0;
    return rm <= lim_for(rn);
  endfunction

  function automatic longint unsigned euclid_gcd(longint unsigned a, longint unsigned b);
    forever begin
      if (a == 0) return b;
      b = b % a;
      if (b == 0) return a;
      a = a % b;
    end
  endfunction

  // Computes the expected fraction and error code for one request.
  function automatic frac_res_t fraction_result(logic [1:0] fn, logic [W-1:0] an_raw,
      logic [W-1:0] ad_raw, logic [W-1:0] bn_raw, logic [W-1:0] bd_raw);
    frac_res_t r;
    bit an, bn, rn, s1n, s2n, ok;
    longint unsigned am, bm, ad, bd, rm, rd, g, l, s1m, s2m;
    an = an_raw[W-1];
    am = an ? longint'(-{32'd0, an_raw}) & WMASK : {32'd0, an_raw};
    if (an && am == 0) am = SMAX + 1;
    bn = bn_raw[W-1];
    bm = bn ? longint'(-{32'd0, bn_raw}) & WMASK : {32'd0, bn_raw};
    if (bn && bm == 0) bm = SMAX + 1;
    ad = ad_raw;
    bd = bd_raw;
    rn = 1'b0;
    rm = 0;
    rd = 0;
    r.err = ERR_OK;
    ok = 1'b1;
    if (ad == 0 || bd == 0 || (fn == FN_DIV && bm == 0)) begin
      r.err = ERR_ZERO;
    end else if (fn == FN_ADD || fn == FN_SUB) begin
      if (fn == FN_SUB && bm != 0) bn = !bn;
      if (ad == bd) begin
        rd = ad;
        ok = sadd_fits(an, am, bn, bm, rn, rm);
      end else begin
        g = euclid_gcd(ad, bd);
        ok = umul_fits(ad / g, bd, WMASK, l);
        if (ok) ok = smul_fits(an, am, 1'b0, l / ad, s1n, s1m);
        if (ok) ok = smul_fits(bn, bm, 1'b0, l / bd, s2n, s2m);
        if (ok) ok = sadd_fits(s1n, s1m, s2n, s2m, rn, rm);
        rd = l;
      end
    end else if (fn == FN_MUL) begin
      ok = smul_fits(an, am, bn, bm, rn, rm);
      if (ok) ok = umul_fits(ad, bd, WMASK, rd);
    end else begin
      ok = smul_fits(an, am, bn, bd, rn, rm);
      if (ok) ok = umul_fits(ad, bm, WMASK, rd);
    end
    if (!ok) r.err = ERR_OVF;
    if (r.err != ERR_OK) begin
      r.num = '0;
      r.den = '0;
    end else begin
      r.num = rn ? W'(-rm) : W'(rm);
      r.den = W'(rd);
    end
    return r;
  endfunction

  // Sender state: bursts of requests separated by random gaps.
  int burst_left = 0;

  // Sends one request and records its expected result once it is accepted.
  // Valid drops only where a gap starts, so a burst keeps it high throughout.
  task automatic send_fraction(logic [1:0] fn, logic [W-1:0] an, logic [W-1:0] ad,
                               logic [W-1:0] bn, logic [W-1:0] bd);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= {bd, bn, ad, an};
    in_tuser <= fn;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(fraction_result(fn, an, ad, bn, bd));
  endtask

  // Receiver stall pattern: runs of ready and of stall, with busy phases toggled.
  always @(posedge clk) begin
    if (!rx_busy) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(0, 3) != 0) && (cycles % 97 > 20);
  end

  // Result checker.
  always @(posedge clk) begin
    frac_res_t want;
    cycles <= cycles + 1;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result num=%h den=%h err=%0d", $time,
                 out_tdata[W-1:0], out_tdata[2*W-1:W], out_tuser);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[W-1:0] !== want.num) begin
          $display("%0t: res_num expected %h actual %h", $time, want.num, out_tdata[W-1:0]);
          errors++;
        end
        if (out_tdata[2*W-1:W] !== want.den) begin
          $display("%0t: res_den expected %h actual %h", $time, want.den,
                   out_tdata[2*W-1:W]);
          errors++;
        end
        if (out_tuser !== want.err) begin
          $display("%0t: error expected %0d actual %0d", $time, want.err, out_tuser);
          errors++;
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("rational_fraction_alu: mismatch");
      $finish;
    end
  end

  function automatic logic [W-1:0] rand_num();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return W'($urandom_range(0, 40)) - 20;
      3: return W'($urandom_range(0, 2000)) - 1000;
      4: return W'($urandom_range(0, 200000)) - 100000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [W-1:0] rand_den();
    case ($urandom_range(0, 6))
      0: return '0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(1, 16);
      3: return $urandom_range(1, 1000);
      4: return $urandom_range(1, 70000);
      default: return $urandom;
    endcase
  endfunction

  // Extremes of each field, every operation, zero denominators, zero divisor,
  // equal denominators, overflow and zero numerators.
  task automatic test_directed();
    send_fraction(FN_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
    send_fraction(FN_ADD, 32'd5, 32'd7, -32'sd3, 32'd7);
    send_fraction(FN_SUB, 32'd1, 32'd4, 32'd1, 32'd6);
    send_fraction(FN_SUB, 32'd3, 32'd9, 32'd3, 32'd9);
    send_fraction(FN_MUL, -32'sd3, 32'd5, 32'd7, 32'd11);
    send_fraction(FN_DIV, 32'd2, 32'd3, -32'sd5, 32'd7);
    send_fraction(FN_DIV, 32'd2, 32'd3, 32'd0, 32'd7);
    send_fraction(FN_ADD, 32'd1, 32'd0, 32'd1, 32'd3);
    send_fraction(FN_MUL, 32'd1, 32'd3, 32'd1, 32'd0);
    send_fraction(FN_ADD, 32'h7FFF_FFFF, 32'd1, 32'd1, 32'd1);
    send_fraction(FN_SUB, 32'h8000_0000, 32'd1, 32'd1, 32'd1);
    send_fraction(FN_ADD, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_fraction(FN_MUL, 32'h8000_0000, 32'd1, 32'hFFFF_FFFF, 32'd1);
    send_fraction(FN_MUL, 32'd2, 32'h1_0000, 32'd3, 32'h1_0000);
    send_fraction(FN_DIV, 32'h8000_0000, 32'd1, 32'h8000_0000, 32'd1);
    send_fraction(FN_ADD, 32'd1, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFE);
    send_fraction(FN_SUB, 32'd0, 32'd6, 32'd0, 32'd10);
    send_fraction(FN_MUL, 32'd0, 32'd5, -32'sd8, 32'd3);
    send_fraction(FN_ADD, 32'd7, 32'd12, 32'd5, 32'd18);
    send_fraction(FN_DIV, -32'sd4, 32'd9, -32'sd6, 32'd10);
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      // Receiver alternates between long clean stretches and stalling stretches.
      if (i % 150 == 0) rx_busy = !rx_busy;
      send_fraction(2'($urandom_range(0, 3)), rand_num(), rand_den(), rand_num(), rand_den());
    end
  endtask

  task automatic test_drain();
    int guard;
    guard = 0;
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (300) @(posedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(900);
    test_drain();
    if (errors == 0 && pending_results.size() == 0) begin
      $display("rational_fraction_alu: match");
    end else begin
      $display("rational_fraction_alu: mismatch");
    end
    $finish;
  end

endmodule
